/* rtl/core/rgb_box_blur_3x3_assert.svh */
// Assertion macros for the 3x3 RGB box blur.
`ifndef RGB_BOX_BLUR_3X3_ASSERT_SVH
`define RGB_BOX_BLUR_3X3_ASSERT_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define RGBBLUR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising clock edge, reset included.
`define RGBBLUR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rgbblur_pkg.sv */
// Shared types and constants of the 3x3 RGB box blur.
`default_nettype none

package rgbblur_pkg;

   // Configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam int CSR_DATA_BITS   = 13;
   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   // Per-word target information, worked out when the word is taken
   typedef struct packed {
      logic has_target;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic image_end;
   } tgt_type;

endpackage

`default_nettype wire

/* rtl/core/rgbblur_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rgbblur_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/rgb_box_blur_3x3.sv */
// Top level of the streaming 3x3 RGB box blur with two line stores in one RAM.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  req     | in        | req_valid/req_stall| action, in_red, in_green, in_blue
//  rsp     | out       | rsp_valid/rsp_stall| out_red, out_green, out_blue, image_end
//  csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata (ready always high)
//
//  One word per cycle while req_stall is low. rsp_valid rises once the word completing a
//  result has passed the stage 1, 2 and 3 registers into the result queue.
//  The line-store RAM is read when a word is taken that has req_action low or lies below the
//  image, and written back the next cycle; back-to-back words on one column are forwarded.
//  req_stall rises only when eight results are queued or in flight (rsp held off).
//  No clearing pass after reset; a register write restarts the image at row 0, column 0.
`default_nettype none

`include "rgb_box_blur_3x3_assert.svh"

module rgb_box_blur_3x3 #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_HEIGHT   = 4096,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [CHANNEL_BITS-1:0]               req_in_red,
   input  logic [CHANNEL_BITS-1:0]               req_in_green,
   input  logic [CHANNEL_BITS-1:0]               req_in_blue,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [CHANNEL_BITS-1:0]               rsp_out_red,
   output logic [CHANNEL_BITS-1:0]               rsp_out_green,
   output logic [CHANNEL_BITS-1:0]               rsp_out_blue,
   output logic                                  rsp_image_end,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [rgbblur_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CB  = CHANNEL_BITS;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int SB  = CB + 4;
   localparam int DIV_SHIFT = SB + 3;
   localparam int DIV_K     = ((2 ** DIV_SHIFT) + 8) / 9;
   localparam int RST_W = (rgbblur_pkg::RESET_WIDTH < MAX_WIDTH) ?
                          rgbblur_pkg::RESET_WIDTH : MAX_WIDTH;
   localparam int RST_H = (rgbblur_pkg::RESET_HEIGHT < MAX_HEIGHT) ?
                          rgbblur_pkg::RESET_HEIGHT : MAX_HEIGHT;
   localparam int QD  = rgbblur_pkg::FIFO_DEPTH;
   localparam int QA  = rgbblur_pkg::FIFO_AW;

   // Configuration and position
   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [CW-1:0] c_ff, c_in;
   logic [RW-1:0] r_ff, r_in;

   // Accept-side decode
   logic                 accept;
   logic                 active;
   logic                 in_image;
   logic [2:0][CB-1:0]   pix;
   logic [RW-1:0]        tr;
   logic [CW-1:0]        tc;
   rgbblur_pkg::tgt_type tgt;

   // Stage 1: RAM data returning
   logic                 s1_valid_ff;
   logic [CW-1:0]        s1_addr_ff;
   logic [2:0][CB-1:0]   s1_pix_ff;
   rgbblur_pkg::tgt_type s1_tgt_ff;
   logic                 s1_fwd_ff;
   logic [6*CB-1:0]      fwd_data_ff;
   logic [6*CB-1:0]      ram_rdata;
   logic [6*CB-1:0]      eff_word;
   logic [6*CB-1:0]      wr_word;
   logic [2:0][CB-1:0]   eff_upper;
   logic [2:0][CB-1:0]   eff_lower;

   logic [2:0][CB-1:0]   window_ff [3][3];

   // Stage 2: window summed
   logic                 s2_valid_ff;
   rgbblur_pkg::tgt_type s2_tgt_ff;
   logic [2:0]           row_ok;
   logic [2:0]           col_ok;
   logic [SB-1:0]        row_sum [3][3];
   logic [SB-1:0]        sum_in [3];

   // Stage 3: divide by nine
   logic                 s3_valid_ff;
   logic                 s3_end_ff;
   logic [SB-1:0]        s3_sum_ff [3];
   logic [2*SB-1:0]      prod [3];
   logic [2:0][CB-1:0]   quot;

   // Result queue and credits
   logic [2:0][CB-1:0]   fifo_pix_ff [QD];
   logic                 fifo_end_ff [QD];
   logic [QA-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [QA:0]          fifo_cnt_ff, fifo_cnt_in;
   logic [QA:0]          cred_ff, cred_in;
   logic                 pop;
   logic                 owe;

   assign csr_ready = 1'b1;
   assign req_stall = (32'(cred_ff) >= QD);
   assign accept    = req_valid && !req_stall;
   assign in_image  = (32'(r_ff) < 32'(h_ff));
   assign active    = accept && (!req_action || !in_image);

   always_comb begin
      pix[0] = in_image ? req_in_red   : '0;
      pix[1] = in_image ? req_in_green : '0;
      pix[2] = in_image ? req_in_blue  : '0;

      tgt = '0;
      if (c_ff != '0) begin
         tgt.has_target = (r_ff != '0);
         tr = r_ff - RW'(1);
         tc = c_ff - CW'(1);
      end else begin
         tgt.has_target = (32'(r_ff) >= 2);
         tr = r_ff - RW'(2);
         tc = CW'(w_ff - WW'(1));
      end
      tgt.has_target = tgt.has_target && (32'(tr) < 32'(h_ff));
      tgt.top_ok     = (tr != '0);
      tgt.bot_ok     = (32'(tr) + 1 < 32'(h_ff));
      tgt.left_ok    = (tc != '0);
      tgt.right_ok   = (32'(tc) + 1 < 32'(w_ff));
      tgt.image_end  = tgt.has_target && (32'(tr) + 1 == 32'(h_ff)) &&
                       (32'(tc) + 1 == 32'(w_ff));
   end

   // Position and register updates
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      c_in = c_ff;
      r_in = r_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rgbblur_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_wdata[rgbblur_pkg::WIDTH_REG_BITS-1:0] == '0) begin
                  w_in = WW'(1);
               end else if (32'(csr_wdata[rgbblur_pkg::WIDTH_REG_BITS-1:0]) > MAX_WIDTH) begin
                  w_in = WW'(MAX_WIDTH);
               end else begin
                  w_in = WW'(csr_wdata[rgbblur_pkg::WIDTH_REG_BITS-1:0]);
               end
            end
            rgbblur_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_wdata[rgbblur_pkg::HEIGHT_REG_BITS-1:0] == '0) begin
                  h_in = HW'(1);
               end else if (32'(csr_wdata[rgbblur_pkg::HEIGHT_REG_BITS-1:0]) > MAX_HEIGHT) begin
                  h_in = HW'(MAX_HEIGHT);
               end else begin
                  h_in = HW'(csr_wdata[rgbblur_pkg::HEIGHT_REG_BITS-1:0]);
               end
            end
            default: begin
               w_in = w_ff;
            end
         endcase
         c_in = '0;
         r_in = '0;
      end else if (active) begin
         if (tgt.image_end) begin
            c_in = '0;
            r_in = '0;
         end else if (32'(c_ff) + 1 >= 32'(w_ff)) begin
            c_in = '0;
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WW'(RST_W);
         h_ff <= HW'(RST_H);
         c_ff <= '0;
         r_ff <= '0;
      end else begin
         w_ff <= w_in;
         h_ff <= h_in;
         c_ff <= c_in;
         r_ff <= r_in;
      end
   end

   // Line stores: upper row in the high half, lower row in the low half
   rgbblur_ram #(
      .WIDTH (6 * CHANNEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (active),
      .rd_addr (c_ff),
      .rd_data (ram_rdata)
   );

   assign eff_word  = s1_fwd_ff ? fwd_data_ff : ram_rdata;
   assign eff_upper = eff_word[6*CB-1:3*CB];
   assign eff_lower = eff_word[3*CB-1:0];
   assign wr_word   = {eff_lower, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active;
      end
      if (active) begin
         s1_addr_ff  <= c_ff;
         s1_pix_ff   <= pix;
         s1_tgt_ff   <= tgt;
         s1_fwd_ff   <= s1_valid_ff && (s1_addr_ff == c_ff);
         fwd_data_ff <= wr_word;
      end
   end

   // Window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               window_ff[k][j] <= '0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            window_ff[k][0] <= window_ff[k][1];
            window_ff[k][1] <= window_ff[k][2];
         end
         window_ff[0][2] <= eff_upper;
         window_ff[1][2] <= eff_lower;
         window_ff[2][2] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_tgt_ff.has_target;
      end
      s2_tgt_ff <= s1_tgt_ff;
   end

   // Masked neighbourhood sum
   assign row_ok = {s2_tgt_ff.bot_ok, 1'b1, s2_tgt_ff.top_ok};
   assign col_ok = {s2_tgt_ff.right_ok, 1'b1, s2_tgt_ff.left_ok};

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            row_sum[ch][k] = (col_ok[0] ? SB'(window_ff[k][0][ch]) : SB'(0)) +
                             SB'(window_ff[k][1][ch]) +
                             (col_ok[2] ? SB'(window_ff[k][2][ch]) : SB'(0));
         end
         sum_in[ch] = (row_ok[0] ? row_sum[ch][0] : SB'(0)) + row_sum[ch][1] +
                      (row_ok[2] ? row_sum[ch][2] : SB'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_end_ff <= s2_tgt_ff.image_end;
      for (int ch = 0; ch < 3; ch++) begin
         s3_sum_ff[ch] <= sum_in[ch];
      end
   end

   // floor(sum / 9) by reciprocal multiply, exact over the sum range
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = (2*SB)'(s3_sum_ff[ch]) * (2*SB)'(DIV_K);
         quot[ch] = prod[ch][DIV_SHIFT +: CB];
      end
   end

   // Result queue
   assign pop       = rsp_valid && !rsp_stall;
   assign owe       = active && tgt.has_target;
   assign rsp_valid = (fifo_cnt_ff != '0);

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      cred_in     = cred_ff;
      if (s3_valid_ff && !pop) begin
         fifo_cnt_in = fifo_cnt_ff + (QA+1)'(1);
      end else if (!s3_valid_ff && pop) begin
         fifo_cnt_in = fifo_cnt_ff - (QA+1)'(1);
      end
      if (owe && !pop) begin
         cred_in = cred_ff + (QA+1)'(1);
      end else if (!owe && pop) begin
         cred_in = cred_ff - (QA+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         cred_ff     <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         cred_ff     <= cred_in;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + QA'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QA'(1);
         end
      end
      if (s3_valid_ff) begin
         fifo_pix_ff[wr_ptr_ff] <= quot;
         fifo_end_ff[wr_ptr_ff] <= s3_end_ff;
      end
   end

   assign rsp_out_red   = fifo_pix_ff[rd_ptr_ff][0];
   assign rsp_out_green = fifo_pix_ff[rd_ptr_ff][1];
   assign rsp_out_blue  = fifo_pix_ff[rd_ptr_ff][2];
   assign rsp_image_end = fifo_end_ff[rd_ptr_ff];

   // Credits cover queued words plus every result still in the pipe
   `RGBBLUR_ASSERT(a_credit_match, clock, reset,
      32'(cred_ff) == 32'(fifo_cnt_ff) + 32'(s1_valid_ff && s1_tgt_ff.has_target) +
      32'(s2_valid_ff) + 32'(s3_valid_ff),
      "credit count out of step with results owed")
   `RGBBLUR_ASSERT(a_push_room, clock, reset, s3_valid_ff |-> (32'(fifo_cnt_ff) < QD),
      "result pushed into a full queue")
   `RGBBLUR_ASSERT(a_col_bound, clock, reset, 32'(c_ff) < 32'(w_ff),
      "column position beyond image width")
   `RGBBLUR_ASSERT_ALWAYS(a_wb_addr, clock,
      (!reset && s1_valid_ff) |-> (s1_addr_ff == $past(c_ff)),
      "line store write-back address differs from read")

endmodule

`default_nettype wire
